// ===== src/slps_pkg.sv =====
// shared types, codes and constants of the sensor driven led pattern sequencer
// no dependencies; used by every module in src

package slps_pkg;

  typedef enum logic [1:0] {
    PAT_BLINK = 2'd0,
    PAT_CHASE = 2'd1,
    PAT_CYCLE = 2'd2,
    PAT_ALERT = 2'd3
  } pattern_e;

  typedef enum logic [2:0] {
    CFG_TEMP_ONLY_MODE      = 3'd0,
    CFG_TEMP_ALERT_LEVEL    = 3'd1,
    CFG_TEMP_WARNING_LEVEL  = 3'd2,
    CFG_LIGHT_ALERT_LEVEL   = 3'd3,
    CFG_LIGHT_WARNING_LEVEL = 3'd4,
    CFG_BLINK_INTERVAL_MS   = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IntvW    = 16;

  // led level bits: bit 0 red, bit 1 yellow, bit 2 green
  localparam logic [2:0] LedR   = 3'b001;
  localparam logic [2:0] LedY   = 3'b010;
  localparam logic [2:0] LedG   = 3'b100;
  localparam logic [2:0] LedOff = 3'b000;

  localparam logic [IntvW-1:0] AlertIntvMs = 16'd120;
  localparam logic [IntvW-1:0] ChaseIntvMs = 16'd180;
  localparam logic [IntvW-1:0] CycleIntvMs = 16'd350;

  localparam logic [7:0] StepCountMax = 8'd255;

  localparam logic signed [11:0] TempAlertRst   = 12'sd300;
  localparam logic signed [11:0] TempWarningRst = 12'sd260;
  localparam logic [11:0]        LightAlertRst   = 12'd500;
  localparam logic [11:0]        LightWarningRst = 12'd1000;
  localparam logic [IntvW-1:0]   BlinkIntvRst    = 16'd500;

  typedef struct packed {
    logic                     temp_only_mode;
    logic signed [11:0]       temp_alert_level;
    logic signed [11:0]       temp_warning_level;
    logic [11:0]              light_alert_level;
    logic [11:0]              light_warning_level;
    logic [IntvW-1:0]         blink_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic                     auto_mode;
    logic [1:0]               chosen_pattern;
    logic signed [11:0]       temperature_tenths;
    logic [11:0]              light_level;
    logic                     motion_seen;
    logic [TimeW-1:0]         now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]               leds;
    pattern_e                 active_pattern;
    logic                     stepped;
  } result_t;

endpackage

// ===== src/slps_cfg_regs.sv =====
// configuration register file of the sequencer
// depends on slps_pkg for the register codes and cfg_t

module slps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [slps_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [slps_pkg::CfgDataW-1:0] wr_data_i,
  output slps_pkg::cfg_t                cfg_o
);

  slps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (slps_pkg::cfg_idx_e'(wr_idx_i))
        slps_pkg::CFG_TEMP_ONLY_MODE:      cfg_d.temp_only_mode      = wr_data_i[0];
        slps_pkg::CFG_TEMP_ALERT_LEVEL:    cfg_d.temp_alert_level    = $signed(wr_data_i[11:0]);
        slps_pkg::CFG_TEMP_WARNING_LEVEL:  cfg_d.temp_warning_level  = $signed(wr_data_i[11:0]);
        slps_pkg::CFG_LIGHT_ALERT_LEVEL:   cfg_d.light_alert_level   = wr_data_i[11:0];
        slps_pkg::CFG_LIGHT_WARNING_LEVEL: cfg_d.light_warning_level = wr_data_i[11:0];
        slps_pkg::CFG_BLINK_INTERVAL_MS:   cfg_d.blink_interval_ms   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_only_mode      <= 1'b0;
      cfg_q.temp_alert_level    <= slps_pkg::TempAlertRst;
      cfg_q.temp_warning_level  <= slps_pkg::TempWarningRst;
      cfg_q.light_alert_level   <= slps_pkg::LightAlertRst;
      cfg_q.light_warning_level <= slps_pkg::LightWarningRst;
      cfg_q.blink_interval_ms   <= slps_pkg::BlinkIntvRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/slps_step_core.sv =====
// pattern selection, step timing and led level decode with the animation state
// depends on slps_pkg for item_t, result_t, cfg_t and the pattern codes

module slps_step_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  slps_pkg::item_t   item_i,
  input  slps_pkg::cfg_t    cfg_i,
  output slps_pkg::result_t res_o
);

  logic [slps_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic [7:0]                 count_q, count_d;
  logic [1:0]                 ph3_q, ph3_d;   // step count mod 3
  slps_pkg::pattern_e         prev_pat_q, prev_pat_d;
  logic                       prev_mode_q, prev_mode_d;
  logic [2:0]                 leds_q, leds_d;

  slps_pkg::pattern_e         auto_pat, pat;
  logic                       changed, step;
  logic [7:0]                 cnt;
  logic [1:0]                 ph3;
  logic [slps_pkg::IntvW-1:0] intv;
  logic [slps_pkg::TimeW-1:0] elapsed;
  logic [2:0]                 step_leds;
  logic                       t_alert, t_warn, l_alert, l_warn;

  assign t_alert = item_i.temperature_tenths >= cfg_i.temp_alert_level;
  assign t_warn  = item_i.temperature_tenths >= cfg_i.temp_warning_level;
  assign l_alert = item_i.light_level <= cfg_i.light_alert_level;
  assign l_warn  = item_i.light_level <= cfg_i.light_warning_level;

  always_comb begin
    if (cfg_i.temp_only_mode) begin
      if (t_alert)     auto_pat = slps_pkg::PAT_ALERT;
      else if (t_warn) auto_pat = slps_pkg::PAT_CHASE;
      else             auto_pat = slps_pkg::PAT_BLINK;
    end else begin
      if (t_alert || l_alert || item_i.motion_seen) auto_pat = slps_pkg::PAT_ALERT;
      else if (t_warn || l_warn)                    auto_pat = slps_pkg::PAT_CHASE;
      else                                          auto_pat = slps_pkg::PAT_CYCLE;
    end
  end

  assign pat = item_i.auto_mode ? auto_pat : slps_pkg::pattern_e'(item_i.chosen_pattern);

  assign changed = (pat != prev_pat_q) || (item_i.auto_mode != prev_mode_q);
  assign cnt     = changed ? 8'd0 : count_q;
  assign ph3     = changed ? 2'd0 : ph3_q;

  always_comb begin
    case (pat)
      slps_pkg::PAT_ALERT: intv = slps_pkg::AlertIntvMs;
      slps_pkg::PAT_CHASE: intv = slps_pkg::ChaseIntvMs;
      slps_pkg::PAT_CYCLE: intv = slps_pkg::CycleIntvMs;
      default:             intv = cfg_i.blink_interval_ms;
    endcase
  end

  assign elapsed = item_i.now_ms - last_time_q;
  assign step    = elapsed >= {{(slps_pkg::TimeW-slps_pkg::IntvW){1'b0}}, intv};

  always_comb begin
    case (pat)
      slps_pkg::PAT_BLINK: step_leds = cnt[0] ? slps_pkg::LedOff
                                              : (slps_pkg::LedR | slps_pkg::LedY | slps_pkg::LedG);
      slps_pkg::PAT_CHASE: begin
        case (ph3)
          2'd0:    step_leds = slps_pkg::LedR;
          2'd1:    step_leds = slps_pkg::LedY;
          default: step_leds = slps_pkg::LedG;
        endcase
      end
      slps_pkg::PAT_CYCLE: begin
        case (cnt[1:0])
          2'd0:    step_leds = slps_pkg::LedR;
          2'd1:    step_leds = slps_pkg::LedY;
          2'd2:    step_leds = slps_pkg::LedG;
          default: step_leds = slps_pkg::LedOff;
        endcase
      end
      default: step_leds = cnt[0] ? (slps_pkg::LedR | slps_pkg::LedY) : slps_pkg::LedR;
    endcase
  end

  always_comb begin
    last_time_d = last_time_q;
    count_d     = count_q;
    ph3_d       = ph3_q;
    prev_pat_d  = prev_pat_q;
    prev_mode_d = prev_mode_q;
    leds_d      = leds_q;
    if (fire_i) begin
      prev_pat_d  = pat;
      prev_mode_d = item_i.auto_mode;
      count_d     = cnt;
      ph3_d       = ph3;
      if (step) begin
        last_time_d = item_i.now_ms;
        leds_d      = step_leds;
        count_d     = cnt + 8'd1;
        // 256 is 1 mod 3, so the phase restarts with the counter wrap
        if (cnt == slps_pkg::StepCountMax) ph3_d = 2'd0;
        else if (ph3 == 2'd2)              ph3_d = 2'd0;
        else                               ph3_d = ph3 + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      count_q     <= '0;
      ph3_q       <= '0;
      prev_pat_q  <= slps_pkg::PAT_BLINK;
      prev_mode_q <= 1'b0;
      leds_q      <= slps_pkg::LedOff;
    end else begin
      last_time_q <= last_time_d;
      count_q     <= count_d;
      ph3_q       <= ph3_d;
      prev_pat_q  <= prev_pat_d;
      prev_mode_q <= prev_mode_d;
      leds_q      <= leds_d;
    end
  end

  assign res_o.leds           = leds_d;
  assign res_o.active_pattern = pat;
  assign res_o.stepped        = step;

endmodule

// ===== src/sensor_driven_led_pattern_sequencer.sv =====
// top level of the sensor driven led pattern sequencer: input and result registers
// depends on slps_pkg, slps_cfg_regs and slps_step_core
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  auto_mode .. now_ms
// out      output     out_valid_o/out_stall_i red_on .. stepped
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one update per cycle sustained while the result is not stalled; an update passes
// from input transfer to result through the input register and then the result register
// the whole per-update work sits between these two registers and writes the
// animation state at the same edge that loads the result
// reset clears all valid flags and the animation state and returns the
// threshold registers to their defaults
// a stalled result holds in place; the input register accepts while it is
// empty, or while the result register is free or drains in the same cycle

module sensor_driven_led_pattern_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // update channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          auto_mode_i,
  input  logic [1:0]                    chosen_pattern_i,
  input  logic signed [11:0]            temperature_tenths_i,
  input  logic [11:0]                   light_level_i,
  input  logic                          motion_seen_i,
  input  logic [31:0]                   now_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          red_on_o,
  output logic                          yellow_on_o,
  output logic                          green_on_o,
  output logic [1:0]                    active_pattern_o,
  output logic                          stepped_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [slps_pkg::CfgDataW-1:0] cfg_data_i
);

  slps_pkg::cfg_t    cfg;
  slps_pkg::item_t   item_q, item_d;
  slps_pkg::result_t res, res_q;
  logic              in_vld_q, out_vld_q;
  logic              adv, fire, in_xfer;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  slps_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_idx_i (cfg_index_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  // result register can load when empty or when its transfer completes now
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign item_d.auto_mode          = auto_mode_i;
  assign item_d.chosen_pattern     = chosen_pattern_i;
  assign item_d.temperature_tenths = temperature_tenths_i;
  assign item_d.light_level        = light_level_i;
  assign item_d.motion_seen        = motion_seen_i;
  assign item_d.now_ms             = now_ms_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      // input register fills on a transfer and empties when its item moves on
      if (in_xfer)     in_vld_q  <= 1'b1;
      else if (fire)   in_vld_q  <= 1'b0;
      if (adv)         out_vld_q <= in_vld_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= item_d;
    if (fire)    res_q  <= res;
  end

  slps_step_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign out_valid_o      = out_vld_q;
  assign red_on_o         = |(res_q.leds & slps_pkg::LedR);
  assign yellow_on_o      = |(res_q.leds & slps_pkg::LedY);
  assign green_on_o       = |(res_q.leds & slps_pkg::LedG);
  assign active_pattern_o = res_q.active_pattern;
  assign stepped_o        = res_q.stepped;

endmodule

// ===== bench/sensor_driven_led_pattern_sequencer_test.sv =====
// self-checking bench for the sensor driven led pattern sequencer: a scoreboard
// class predicts each led result, plain tasks drive updates and register writes
// depends on slps_pkg and sensor_driven_led_pattern_sequencer from src
`timescale 1ns / 100ps

module sensor_driven_led_pattern_sequencer_test;
  import slps_pkg::*;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int QuietLimit = 1000;

  // scoreboard: own copy of the registers and animation state, a queue of the
  // led results still owed by the block, and a mismatch count
  class led_sequence_board;
    logic              temp_only;
    logic signed [11:0] temp_alert;
    logic signed [11:0] temp_warn;
    logic [11:0]       light_alert;
    logic [11:0]       light_warn;
    logic [15:0]       blink_ms;

    logic [31:0]       last_step;
    logic [7:0]        step_cnt;
    pattern_e          prev_pat;
    logic              prev_mode;
    logic [2:0]        leds;

    result_t           led_outcomes[$];
    int                errors;

    function new();
      temp_only   = 1'b0;
      temp_alert  = TempAlertRst;
      temp_warn   = TempWarningRst;
      light_alert = LightAlertRst;
      light_warn  = LightWarningRst;
      blink_ms    = BlinkIntvRst;
      last_step   = '0;
      step_cnt    = '0;
      prev_pat    = PAT_BLINK;
      prev_mode   = 1'b0;
      leds        = LedOff;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_TEMP_ONLY_MODE:      temp_only   = data[0];
        CFG_TEMP_ALERT_LEVEL:    temp_alert  = data[11:0];
        CFG_TEMP_WARNING_LEVEL:  temp_warn   = data[11:0];
        CFG_LIGHT_ALERT_LEVEL:   light_alert = data[11:0];
        CFG_LIGHT_WARNING_LEVEL: light_warn  = data[11:0];
        CFG_BLINK_INTERVAL_MS:   blink_ms    = data;
        default: ;
      endcase
    endfunction

    // advance the animation by one accepted update and queue the result
    function void note_update(item_t u);
      pattern_e           pat;
      logic signed [11:0] temp;
      logic [31:0]        span;
      logic [31:0]        elapsed;
      result_t            want;
      temp = u.temperature_tenths;
      if (u.auto_mode) begin
        if (temp_only) begin
          if (temp >= temp_alert) pat = PAT_ALERT;
          else if (temp >= temp_warn) pat = PAT_CHASE;
          else pat = PAT_BLINK;
        end else if (temp >= temp_alert || u.light_level <= light_alert || u.motion_seen) begin
          pat = PAT_ALERT;
        end else if (temp >= temp_warn || u.light_level <= light_warn) begin
          pat = PAT_CHASE;
        end else begin
          pat = PAT_CYCLE;
        end
      end else begin
        pat = pattern_e'(u.chosen_pattern);
      end
      // new pattern or mode restarts the sequence
      if (pat != prev_pat || u.auto_mode != prev_mode) begin
        step_cnt  = '0;
        prev_pat  = pat;
        prev_mode = u.auto_mode;
      end
      case (pat)
        PAT_ALERT: span = {16'd0, AlertIntvMs};
        PAT_CHASE: span = {16'd0, ChaseIntvMs};
        PAT_CYCLE: span = {16'd0, CycleIntvMs};
        default:   span = {16'd0, blink_ms};
      endcase
      elapsed      = u.now_ms - last_step;
      want.stepped = (elapsed >= span);
      if (want.stepped) begin
        last_step = u.now_ms;
        case (pat)
          PAT_BLINK: leds = step_cnt[0] ? LedOff : (LedR | LedY | LedG);
          PAT_CHASE: begin
            case (step_cnt % 3)
              0:       leds = LedR;
              1:       leds = LedY;
              default: leds = LedG;
            endcase
          end
          PAT_CYCLE: begin
            case (step_cnt[1:0])
              2'd0:    leds = LedR;
              2'd1:    leds = LedY;
              2'd2:    leds = LedG;
              default: leds = LedOff;
            endcase
          end
          default: leds = step_cnt[0] ? (LedR | LedY) : LedR;
        endcase
        step_cnt = step_cnt + 8'd1;
      end
      want.leds           = leds;
      want.active_pattern = pat;
      led_outcomes.push_back(want);
    endfunction

    function void report(string what, logic [1:0] want_v, logic [1:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %b, actual %b", $time, what, want_v, got_v);
      end
    endfunction

    function void check_result(logic [2:0] leds_seen, logic [1:0] pat_seen, logic step_seen);
      result_t want;
      if (led_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual leds %b pattern %b stepped %b",
                 $time, leds_seen, pat_seen, step_seen);
        return;
      end
      want = led_outcomes.pop_front();
      report("red",     {1'b0, want.leds[0]},  {1'b0, leds_seen[0]});
      report("yellow",  {1'b0, want.leds[1]},  {1'b0, leds_seen[1]});
      report("green",   {1'b0, want.leds[2]},  {1'b0, leds_seen[2]});
      report("pattern", want.active_pattern,   pat_seen);
      report("stepped", {1'b0, want.stepped},  {1'b0, step_seen});
    endfunction

    function int pending();
      return led_outcomes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        auto_mode_i = 1'b0;
  logic [1:0]  chosen_pattern_i = '0;
  logic signed [11:0] temperature_tenths_i = '0;
  logic [11:0] light_level_i = '0;
  logic        motion_seen_i = 1'b0;
  logic [31:0] now_ms_i = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        red_on_o;
  logic        yellow_on_o;
  logic        green_on_o;
  logic [1:0]  active_pattern_o;
  logic        stepped_o;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  led_sequence_board board = new();

  // no idling on either side while set
  bit          calm = 1'b0;
  // running millisecond clock used by well-formed update sequences
  logic [31:0] now_cursor = '0;
  int          quiet_cycles = 0;

  sensor_driven_led_pattern_sequencer uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .auto_mode_i          (auto_mode_i),
    .chosen_pattern_i     (chosen_pattern_i),
    .temperature_tenths_i (temperature_tenths_i),
    .light_level_i        (light_level_i),
    .motion_seen_i        (motion_seen_i),
    .now_ms_i             (now_ms_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .red_on_o             (red_on_o),
    .yellow_on_o          (yellow_on_o),
    .green_on_o           (green_on_o),
    .active_pattern_o     (active_pattern_o),
    .stepped_o            (stepped_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result({green_on_o, yellow_on_o, red_on_o}, active_pattern_o, stepped_o);
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 14);
  end

  // hang detector: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one update, hold it until transferred, then maybe idle a little
  task automatic send_update(item_t u);
    in_valid_i           <= 1'b1;
    auto_mode_i          <= u.auto_mode;
    chosen_pattern_i     <= u.chosen_pattern;
    temperature_tenths_i <= u.temperature_tenths;
    light_level_i        <= u.light_level;
    motion_seen_i        <= u.motion_seen;
    now_ms_i             <= u.now_ms;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    board.note_update(u);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(logic mode, logic [1:0] pat, logic signed [11:0] temp,
                             logic [11:0] light, logic motion, logic [31:0] now);
    item_t u;
    u.auto_mode          = mode;
    u.chosen_pattern     = pat;
    u.temperature_tenths = temp;
    u.light_level        = light;
    u.motion_seen        = motion;
    u.now_ms             = now;
    send_update(u);
  endtask

  // stop sending and wait until every owed result has been transferred
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // pipeline depth is two registers, leave a little margin
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    board.set_reg(idx, data);
  endtask

  // rewrite every register with the block idle
  task automatic program_regs(logic only, logic signed [11:0] ta, logic signed [11:0] tw,
                              logic [11:0] la, logic [11:0] lw, logic [15:0] bl);
    drain();
    write_reg(CFG_TEMP_ONLY_MODE,      {15'd0, only});
    write_reg(CFG_TEMP_ALERT_LEVEL,    {{4{ta[11]}}, ta});
    write_reg(CFG_TEMP_WARNING_LEVEL,  {{4{tw[11]}}, tw});
    write_reg(CFG_LIGHT_ALERT_LEVEL,   {4'd0, la});
    write_reg(CFG_LIGHT_WARNING_LEVEL, {4'd0, lw});
    write_reg(CFG_BLINK_INTERVAL_MS,   bl);
    cfg_valid_i <= 1'b0;
  endtask

  // temperatures clustered on the configured levels, plus wide values
  function automatic logic signed [11:0] near_temp();
    logic signed [11:0] t;
    case ($urandom_range(0, 7))
      0:       t = board.temp_alert;
      1:       t = board.temp_alert - 12'sd1;
      2:       t = board.temp_warn;
      3:       t = board.temp_warn - 12'sd1;
      4:       t = board.temp_alert + 12'sd1;
      5:       t = 12'($urandom);
      default: t = 12'($urandom_range(0, 1650) - 400);
    endcase
    return t;
  endfunction

  function automatic logic [11:0] near_light();
    logic [11:0] l;
    case ($urandom_range(0, 7))
      0:       l = board.light_alert;
      1:       l = board.light_alert + 12'd1;
      2:       l = board.light_warn;
      3:       l = board.light_warn + 12'd1;
      4:       l = 12'd0;
      5:       l = 12'hfff;
      default: l = 12'($urandom);
    endcase
    return l;
  endfunction

  // time between updates, mostly around one of the step intervals
  function automatic logic [31:0] next_delta();
    logic [31:0] d;
    case ($urandom_range(0, 9))
      0:       d = $urandom_range(0, 20);
      1:       d = $urandom_range(119, 121);
      2:       d = $urandom_range(179, 181);
      3:       d = $urandom_range(349, 351);
      4:       d = {16'd0, board.blink_ms} + $urandom_range(0, 2) - 1;
      5:       d = $urandom_range(0, 1000);
      6:       d = $urandom_range(1, 60);
      7:       d = 32'd120;
      8:       d = 32'd180;
      default: d = 32'd350;
    endcase
    return d;
  endfunction

  // mostly well-formed sequences: one mode and pattern, steady sensors,
  // time moving forward near an interval; the rest is pure noise
  task automatic random_phase(int count, bit with_overflow);
    int                 sent;
    int                 run_len;
    bit                 paused;
    logic               mode;
    logic [1:0]         pat;
    logic signed [11:0] temp;
    logic [11:0]        light;
    logic               motion;
    sent   = 0;
    paused = 1'b0;
    if (with_overflow) begin
      // long manual chase run so the step counter wraps past 255
      for (int i = 0; i < 270; i++) begin
        now_cursor = now_cursor + ((i % 5 == 0) ? 32'd181 : 32'd180);
        send_fields(1'b0, PAT_CHASE, near_temp(), near_light(), 1'b0, now_cursor);
      end
    end
    while (sent < count) begin
      if (!paused && sent >= count / 2) begin
        // sender holds off until the result side has caught up
        drain();
        paused = 1'b1;
      end
      // occasional jump of the clock: backwards, forwards or near the wrap
      if ($urandom_range(0, 19) == 0) begin
        now_cursor = $urandom_range(0, 1) ? $urandom : 32'hffff_ff00 + $urandom_range(0, 255);
      end
      if ($urandom_range(0, 99) < 80) begin
        mode    = 1'($urandom_range(0, 1));
        pat     = 2'($urandom_range(0, 3));
        temp    = near_temp();
        light   = near_light();
        motion  = ($urandom_range(0, 3) == 0);
        run_len = $urandom_range(2, 30);
        repeat (run_len) begin
          case ($urandom_range(0, 20))
            0:       temp = near_temp();
            1:       light = near_light();
            2:       motion = !motion;
            default: ;
          endcase
          now_cursor = now_cursor + next_delta();
          send_fields(mode, pat, temp, light, motion, now_cursor);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_fields(1'($urandom), 2'($urandom), 12'($urandom), 12'($urandom),
                      1'($urandom), $urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values
    // blink below and at its interval, then every manual pattern in turn
    send_fields(1'b0, PAT_BLINK, 12'sd0, 12'd2000, 1'b0, 32'd0);
    send_fields(1'b0, PAT_BLINK, 12'sd0, 12'd2000, 1'b0, 32'd499);
    send_fields(1'b0, PAT_BLINK, 12'sd0, 12'd2000, 1'b0, 32'd500);
    send_fields(1'b0, PAT_BLINK, 12'sd0, 12'd2000, 1'b0, 32'd1000);
    send_fields(1'b0, PAT_CHASE, 12'sd0, 12'd2000, 1'b0, 32'd1100);
    send_fields(1'b0, PAT_CHASE, 12'sd0, 12'd2000, 1'b0, 32'd1180);
    send_fields(1'b0, PAT_CHASE, 12'sd0, 12'd2000, 1'b0, 32'd1360);
    send_fields(1'b0, PAT_CHASE, 12'sd0, 12'd2000, 1'b0, 32'd1540);
    send_fields(1'b0, PAT_CYCLE, 12'sd0, 12'd2000, 1'b0, 32'd1890);
    send_fields(1'b0, PAT_CYCLE, 12'sd0, 12'd2000, 1'b0, 32'd2240);
    send_fields(1'b0, PAT_ALERT, 12'sd0, 12'd2000, 1'b0, 32'd2360);
    send_fields(1'b0, PAT_ALERT, 12'sd0, 12'd2000, 1'b0, 32'd2480);
    // auto selection right on each threshold and motion
    send_fields(1'b1, PAT_BLINK, 12'sd300, 12'd2000, 1'b0, 32'd2600);
    send_fields(1'b1, PAT_BLINK, 12'sd299, 12'd1001, 1'b0, 32'd2950);
    send_fields(1'b1, PAT_BLINK, 12'sd260, 12'd4095, 1'b0, 32'd3130);
    send_fields(1'b1, PAT_BLINK, 12'sd259, 12'd500,  1'b0, 32'd3250);
    send_fields(1'b1, PAT_BLINK, 12'sd259, 12'd1000, 1'b0, 32'd3430);
    send_fields(1'b1, PAT_BLINK, 12'sd259, 12'd1001, 1'b1, 32'd3550);
    // field extremes, clock wrap and a clock going backwards
    send_fields(1'b1, PAT_ALERT, 12'sd2047,  12'd0,    1'b1, 32'hffff_ffff);
    send_fields(1'b1, PAT_ALERT, -12'sd2048, 12'd4095, 1'b0, 32'd5);
    send_fields(1'b0, PAT_ALERT, -12'sd400,  12'd4095, 1'b0, 32'd3);
    send_fields(1'b0, PAT_CYCLE, 12'sd1250,  12'd0,    1'b1, 32'hffff_ffff);
    now_cursor = 32'd4000;

    random_phase(200, 1'b1);

    // temperature-only selection at reset levels
    program_regs(1'b1, 12'sd300, 12'sd260, 12'd500, 12'd1000, 16'd500);
    random_phase(200, 1'b0);

    // reversed thresholds, shortest blink, no idling anywhere
    calm = 1'b1;
    program_regs(1'b0, -12'sd400, 12'sd1250, 12'd3000, 12'd200, 16'd1);
    random_phase(200, 1'b0);
    calm = 1'b0;

    // temperature-only with reversed levels and longest blink
    program_regs(1'b1, 12'sd1250, -12'sd400, 12'd4095, 12'd0, 16'hffff);
    random_phase(200, 1'b0);

    // widest levels and zero blink interval, so blink steps on every update
    program_regs(1'b0, 12'sd2047, -12'sd2048, 12'd0, 12'd4095, 16'd0);
    random_phase(200, 1'b1);

    // random levels inside the working ranges
    program_regs(1'($urandom_range(0, 1)), 12'($urandom_range(0, 1650) - 400),
                 12'($urandom_range(0, 1650) - 400), 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)), 16'($urandom_range(1, 65535)));
    random_phase(200, 1'b0);

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
